// ----- src/sti_pkg.sv -----
// Shared constants for the segment/triangle intersection unit.
package sti_pkg;

  // Width of one packed point on the input ports.
  localparam int unsigned FIELD_W = 48;

  // Coordinate axes of a point.
  localparam int unsigned AXES   = 3;
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;
  localparam int unsigned AXIS_Z = 2;

endpackage

// ----- src/segment_triangle_intersect_unit.sv -----
// Pipelined segment against triangle intersection test, one pair per cycle.
//
// Input channel: in_valid_i / in_stall_o carry one item, a triangle (three
// vertices) and a segment (start, end), each point packed as three signed
// coordinates of COORD_BITS bits, x lowest. The binary point sits anywhere:
// all math is exact on the raw codes, so the fraction width changes nothing.
// Output channel: out_valid_o / out_stall_i carry the hit flag and the
// crossing point; the point reads zero on a miss.
// Most of the pipeline depth is the quotient pipeline, which resolves one
// bit of the interpolation ratio per stage for all three axes. Throughput
// is one item per cycle while the receiver does not stall the output.
// When the output register holds an item and the receiver stalls, the whole
// pipe freezes and in_stall_o rises in the same cycle; nothing is lost or
// repeated. Bubbles are not squeezed out.
// Reset clears every stage's valid bit; the data registers are not reset.
module segment_triangle_intersect_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sti_pkg::FIELD_W-1:0]    tri_vertex_a_i,
  input  logic [sti_pkg::FIELD_W-1:0]    tri_vertex_b_i,
  input  logic [sti_pkg::FIELD_W-1:0]    tri_vertex_c_i,
  input  logic [sti_pkg::FIELD_W-1:0]    seg_start_i,
  input  logic [sti_pkg::FIELD_W-1:0]    seg_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic signed [COORD_BITS-1:0]   hit_x_o,
  output logic signed [COORD_BITS-1:0]   hit_y_o,
  output logic signed [COORD_BITS-1:0]   hit_z_o
);
  import sti_pkg::*;

  // Widths of the intermediate values, all exact.
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned DW   = CW + 1;          // coordinate difference
  localparam int unsigned PW   = 2 * DW;          // product of two differences
  localparam int unsigned NW   = PW + 1;          // cross product component
  localparam int unsigned DPW  = DW + NW;         // difference times normal
  localparam int unsigned DTW  = DPW + 2;         // plane distance
  localparam int unsigned SW   = DTW + 1;         // sum of distance magnitudes
  localparam int unsigned NUMW = DTW + DW;        // dividend and remainder
  localparam int unsigned EPW  = 2 * NW;          // edge normal times normal
  localparam int unsigned ESW  = EPW + 2;         // edge test sum
  localparam int unsigned PKW  = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;

  // Stage map.
  localparam int unsigned ST_DIFF = 0;
  localparam int unsigned ST_NPRD = 1;
  localparam int unsigned ST_NRM  = 2;
  localparam int unsigned ST_DPRD = 3;
  localparam int unsigned ST_DOT  = 4;
  localparam int unsigned ST_SIDE = 5;
  localparam int unsigned ST_NUM  = 6;
  localparam int unsigned ST_DIV  = 7;
  localparam int unsigned ST_RND  = ST_DIV + CW + 1;
  localparam int unsigned ST_X    = ST_RND + 1;
  localparam int unsigned ST_ECP  = ST_X + 1;
  localparam int unsigned ST_EN   = ST_ECP + 1;
  localparam int unsigned ST_EPRD = ST_EN + 1;
  localparam int unsigned ST_ESUM = ST_EPRD + 1;
  localparam int unsigned ST_OUT  = ST_ESUM + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  typedef logic signed [CW-1:0]   crd_t;
  typedef logic signed [DW-1:0]   dif_t;
  typedef logic signed [PW-1:0]   prd_t;
  typedef logic signed [NW-1:0]   nrm_t;
  typedef logic signed [DPW-1:0]  dpr_t;
  typedef logic signed [DTW-1:0]  dot_t;
  typedef logic        [DTW-1:0]  mag_t;
  typedef logic        [DW-1:0]   adc_t;
  typedef logic        [SW-1:0]   sum_t;
  typedef logic        [NUMW-1:0] num_t;
  typedef logic        [NUMW:0]   trl_t;
  typedef logic        [DW-1:0]   quo_t;
  typedef logic signed [EPW-1:0]  epr_t;
  typedef logic signed [ESW-1:0]  esm_t;

  typedef crd_t [AXES-1:0]  pnt_t;

  typedef struct packed {
    pnt_t [AXES-1:0]          v;
    pnt_t                     p0;
    dif_t [AXES-1:0]          e1;
    dif_t [AXES-1:0]          e2;
    dif_t [AXES-1:0]          w1;
    dif_t [AXES-1:0]          w2;
    dif_t [AXES-1:0]          dc;
    prd_t [5:0]               nprd;
    nrm_t [AXES-1:0]          nrm;
    dpr_t [5:0]               dprd;
    dot_t                     da;
    dot_t                     db;
    logic                     live;
    mag_t                     d1;
    sum_t                     s;
    num_t [AXES-1:0]          rem;
    quo_t [AXES-1:0]          q;
    pnt_t                     x;
    prd_t [AXES-1:0][5:0]     ecp;
    nrm_t [AXES-1:0][AXES-1:0] en;
    epr_t [AXES-1:0][AXES-1:0] eprd;
    esm_t [AXES-1:0]          esum;
    logic                     hit;
  } pipe_t;

  pipe_t           pipe_d [NST];
  pipe_t           pipe_q [NST];
  logic [NST-1:0]  vld_q;
  logic            adv;

  // Freeze the pipe only when a finished item sits unread at the output.
  assign adv        = !(vld_q[ST_OUT] && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    logic [PKW-1:0] word [5];
    pnt_t           pin  [5];
    dif_t [AXES-1:0] ed;
    dif_t [AXES-1:0] rl;
    mag_t           d2;
    adc_t           adc;
    trl_t           ts;
    dif_t           xw;
    logic           in_tri;
    int unsigned    j;

    word[0] = PKW'(tri_vertex_a_i);
    word[1] = PKW'(tri_vertex_b_i);
    word[2] = PKW'(tri_vertex_c_i);
    word[3] = PKW'(seg_start_i);
    word[4] = PKW'(seg_end_i);
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < AXES; k++) begin
        pin[i][k] = crd_t'(word[i][k*CW +: CW]);
      end
    end

    // Edges from vertex a, endpoint offsets from vertex a, segment direction.
    pipe_d[ST_DIFF] = '0;
    pipe_d[ST_DIFF].v[0] = pin[0];
    pipe_d[ST_DIFF].v[1] = pin[1];
    pipe_d[ST_DIFF].v[2] = pin[2];
    pipe_d[ST_DIFF].p0   = pin[3];
    for (int k = 0; k < AXES; k++) begin
      pipe_d[ST_DIFF].e1[k] = dif_t'(pin[1][k]) - dif_t'(pin[0][k]);
      pipe_d[ST_DIFF].e2[k] = dif_t'(pin[2][k]) - dif_t'(pin[0][k]);
      pipe_d[ST_DIFF].w1[k] = dif_t'(pin[3][k]) - dif_t'(pin[0][k]);
      pipe_d[ST_DIFF].w2[k] = dif_t'(pin[4][k]) - dif_t'(pin[0][k]);
      pipe_d[ST_DIFF].dc[k] = dif_t'(pin[4][k]) - dif_t'(pin[3][k]);
    end

    // Normal partial products.
    pipe_d[ST_NPRD] = pipe_q[ST_NPRD-1];
    pipe_d[ST_NPRD].nprd[0] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_Y])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_Z]);
    pipe_d[ST_NPRD].nprd[1] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_Z])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_Y]);
    pipe_d[ST_NPRD].nprd[2] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_Z])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_X]);
    pipe_d[ST_NPRD].nprd[3] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_X])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_Z]);
    pipe_d[ST_NPRD].nprd[4] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_X])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_Y]);
    pipe_d[ST_NPRD].nprd[5] = prd_t'(pipe_q[ST_NPRD-1].e1[AXIS_Y])
                            * prd_t'(pipe_q[ST_NPRD-1].e2[AXIS_X]);

    pipe_d[ST_NRM] = pipe_q[ST_NRM-1];
    for (int k = 0; k < AXES; k++) begin
      pipe_d[ST_NRM].nrm[k] = nrm_t'(pipe_q[ST_NRM-1].nprd[2*k])
                            - nrm_t'(pipe_q[ST_NRM-1].nprd[2*k+1]);
    end

    // Endpoint distances to the plane, scaled by the normal length.
    pipe_d[ST_DPRD] = pipe_q[ST_DPRD-1];
    for (int k = 0; k < AXES; k++) begin
      pipe_d[ST_DPRD].dprd[k]   = dpr_t'(pipe_q[ST_DPRD-1].w1[k])
                                * dpr_t'(pipe_q[ST_DPRD-1].nrm[k]);
      pipe_d[ST_DPRD].dprd[3+k] = dpr_t'(pipe_q[ST_DPRD-1].w2[k])
                                * dpr_t'(pipe_q[ST_DPRD-1].nrm[k]);
    end

    pipe_d[ST_DOT] = pipe_q[ST_DOT-1];
    pipe_d[ST_DOT].da = dot_t'(pipe_q[ST_DOT-1].dprd[0]) + dot_t'(pipe_q[ST_DOT-1].dprd[1])
                      + dot_t'(pipe_q[ST_DOT-1].dprd[2]);
    pipe_d[ST_DOT].db = dot_t'(pipe_q[ST_DOT-1].dprd[3]) + dot_t'(pipe_q[ST_DOT-1].dprd[4])
                      + dot_t'(pipe_q[ST_DOT-1].dprd[5]);

    // Reject when both endpoints lie strictly on one side, or segment in plane or flat triangle.
    pipe_d[ST_SIDE] = pipe_q[ST_SIDE-1];
    pipe_d[ST_SIDE].d1 = pipe_q[ST_SIDE-1].da[DTW-1] ? mag_t'(-pipe_q[ST_SIDE-1].da)
                                                     : mag_t'(pipe_q[ST_SIDE-1].da);
    d2 = pipe_q[ST_SIDE-1].db[DTW-1] ? mag_t'(-pipe_q[ST_SIDE-1].db)
                                     : mag_t'(pipe_q[ST_SIDE-1].db);
    pipe_d[ST_SIDE].s = sum_t'(pipe_d[ST_SIDE].d1) + sum_t'(d2);
    pipe_d[ST_SIDE].live = !((pipe_q[ST_SIDE-1].da != '0) && (pipe_q[ST_SIDE-1].db != '0)
                             && (pipe_q[ST_SIDE-1].da[DTW-1] == pipe_q[ST_SIDE-1].db[DTW-1]))
                           && (pipe_d[ST_SIDE].s != '0);

    // Dividend |da| * |dc| per axis.
    pipe_d[ST_NUM] = pipe_q[ST_NUM-1];
    for (int k = 0; k < AXES; k++) begin
      adc = pipe_q[ST_NUM-1].dc[k][DW-1] ? adc_t'(-pipe_q[ST_NUM-1].dc[k])
                                         : adc_t'(pipe_q[ST_NUM-1].dc[k]);
      pipe_d[ST_NUM].rem[k] = num_t'(pipe_q[ST_NUM-1].d1) * num_t'(adc);
      pipe_d[ST_NUM].q[k]   = '0;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (int st = 0; st <= CW; st++) begin
      j = CW - st;
      pipe_d[ST_DIV+st] = pipe_q[ST_DIV+st-1];
      for (int k = 0; k < AXES; k++) begin
        ts = trl_t'(pipe_q[ST_DIV+st-1].s) << j;
        if (trl_t'(pipe_q[ST_DIV+st-1].rem[k]) >= ts) begin
          pipe_d[ST_DIV+st].rem[k] = num_t'(trl_t'(pipe_q[ST_DIV+st-1].rem[k]) - ts);
          pipe_d[ST_DIV+st].q[k][j] = 1'b1;
        end
      end
    end

    // Round half up on the remainder.
    pipe_d[ST_RND] = pipe_q[ST_RND-1];
    for (int k = 0; k < AXES; k++) begin
      if ((trl_t'(pipe_q[ST_RND-1].rem[k]) << 1) >= trl_t'(pipe_q[ST_RND-1].s)) begin
        pipe_d[ST_RND].q[k] = pipe_q[ST_RND-1].q[k] + quo_t'(1);
      end
    end

    // Crossing point: step from the start toward the end.
    pipe_d[ST_X] = pipe_q[ST_X-1];
    for (int k = 0; k < AXES; k++) begin
      if (pipe_q[ST_X-1].dc[k][DW-1]) begin
        xw = dif_t'(pipe_q[ST_X-1].p0[k]) - dif_t'(pipe_q[ST_X-1].q[k]);
      end else begin
        xw = dif_t'(pipe_q[ST_X-1].p0[k]) + dif_t'(pipe_q[ST_X-1].q[k]);
      end
      pipe_d[ST_X].x[k] = crd_t'(xw);
    end

    // Edge tests: (Vnext - V) x (X - Vnext), then dotted with the normal.
    pipe_d[ST_ECP] = pipe_q[ST_ECP-1];
    for (int i = 0; i < AXES; i++) begin
      for (int k = 0; k < AXES; k++) begin
        ed[k] = dif_t'(pipe_q[ST_ECP-1].v[(i+1)%AXES][k]) - dif_t'(pipe_q[ST_ECP-1].v[i][k]);
        rl[k] = dif_t'(pipe_q[ST_ECP-1].x[k]) - dif_t'(pipe_q[ST_ECP-1].v[(i+1)%AXES][k]);
      end
      pipe_d[ST_ECP].ecp[i][0] = prd_t'(ed[AXIS_Y]) * prd_t'(rl[AXIS_Z]);
      pipe_d[ST_ECP].ecp[i][1] = prd_t'(ed[AXIS_Z]) * prd_t'(rl[AXIS_Y]);
      pipe_d[ST_ECP].ecp[i][2] = prd_t'(ed[AXIS_Z]) * prd_t'(rl[AXIS_X]);
      pipe_d[ST_ECP].ecp[i][3] = prd_t'(ed[AXIS_X]) * prd_t'(rl[AXIS_Z]);
      pipe_d[ST_ECP].ecp[i][4] = prd_t'(ed[AXIS_X]) * prd_t'(rl[AXIS_Y]);
      pipe_d[ST_ECP].ecp[i][5] = prd_t'(ed[AXIS_Y]) * prd_t'(rl[AXIS_X]);
    end

    pipe_d[ST_EN] = pipe_q[ST_EN-1];
    for (int i = 0; i < AXES; i++) begin
      for (int k = 0; k < AXES; k++) begin
        pipe_d[ST_EN].en[i][k] = nrm_t'(pipe_q[ST_EN-1].ecp[i][2*k])
                               - nrm_t'(pipe_q[ST_EN-1].ecp[i][2*k+1]);
      end
    end

    pipe_d[ST_EPRD] = pipe_q[ST_EPRD-1];
    for (int i = 0; i < AXES; i++) begin
      for (int k = 0; k < AXES; k++) begin
        pipe_d[ST_EPRD].eprd[i][k] = epr_t'(pipe_q[ST_EPRD-1].en[i][k])
                                   * epr_t'(pipe_q[ST_EPRD-1].nrm[k]);
      end
    end

    pipe_d[ST_ESUM] = pipe_q[ST_ESUM-1];
    for (int i = 0; i < AXES; i++) begin
      pipe_d[ST_ESUM].esum[i] = esm_t'(pipe_q[ST_ESUM-1].eprd[i][0])
                              + esm_t'(pipe_q[ST_ESUM-1].eprd[i][1])
                              + esm_t'(pipe_q[ST_ESUM-1].eprd[i][2]);
    end

    // A zero edge test counts as inside; zero the point on a miss.
    pipe_d[ST_OUT] = pipe_q[ST_OUT-1];
    in_tri = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (pipe_q[ST_OUT-1].esum[i][ESW-1]) begin
        in_tri = 1'b0;
      end
    end
    pipe_d[ST_OUT].hit = pipe_q[ST_OUT-1].live && in_tri;
    if (!pipe_d[ST_OUT].hit) begin
      pipe_d[ST_OUT].x = '0;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int st = 0; st < NST; st++) begin
        pipe_q[st] <= pipe_d[st];
      end
    end
  end

  assign out_valid_o = vld_q[ST_OUT];
  assign hit_o       = pipe_q[ST_OUT].hit;
  assign hit_x_o     = pipe_q[ST_OUT].x[AXIS_X];
  assign hit_y_o     = pipe_q[ST_OUT].x[AXIS_Y];
  assign hit_z_o     = pipe_q[ST_OUT].x[AXIS_Z];

endmodule

// ----- src/sti_check.sv -----
// Port-level checks for the intersection unit, bound to its top level.
module sti_check #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic signed [COORD_BITS-1:0] hit_x_o,
  input logic signed [COORD_BITS-1:0] hit_y_o,
  input logic signed [COORD_BITS-1:0] hit_z_o
);

  // Hold a stalled result item.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(hit_x_o)
      && $stable(hit_y_o) && $stable(hit_z_o))
    else $error("stalled result item changed");

  // Drive a zero point on a miss.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0)
    else $error("miss item carries a nonzero point");

  // Stall the input only behind an unread result item.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result item");

  // Show no result item once reset has been seen at an edge.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result item valid during reset");

endmodule

bind segment_triangle_intersect_unit sti_check #(.COORD_BITS(COORD_BITS)) u_sti_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .hit_x_o     (hit_x_o),
  .hit_y_o     (hit_y_o),
  .hit_z_o     (hit_z_o)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the segment/triangle intersection unit.
`timescale 1ns / 100ps

module tb;
  import sti_pkg::*;

  localparam int unsigned CB = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1400;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
    coord_t z;
  } crossing_t;

  typedef struct {
    logic [FIELD_W-1:0] a, b, c, p0, p1;
    logic               known;  // result typed in below
    crossing_t          want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FIELD_W-1:0] tri_vertex_a_i = '0, tri_vertex_b_i = '0, tri_vertex_c_i = '0;
  logic [FIELD_W-1:0] seg_start_i = '0, seg_end_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  coord_t hit_x_o, hit_y_o, hit_z_o;

  crossing_t pending_hits[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 11, recv_idle_pct = 50;
  bit hold_off = 1'b0;  // long receiver stall to fill the pipe
  bit stim_done = 1'b0;

  segment_triangle_intersect_unit #(.COORD_BITS(CB)) u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [FIELD_W-1:0] pt(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // Exact integer predictor; 128-bit signed math covers every product.
  function automatic crossing_t predict_crossing(logic [FIELD_W-1:0] a, b, c, p0, p1);
    logic signed [127:0] v[3][3], s0[3], s1[3], e1[3], e2[3], nrm[3], xp[3];
    logic signed [127:0] ed[3], rl[3], cr[3];
    logic signed [127:0] da, db, ada, sum, dc, num, q, rem, dt;
    logic [FIELD_W-1:0] w[3];
    crossing_t r;
    int j;
    r = '0;
    w[0] = a; w[1] = b; w[2] = c;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = coord_t'(w[i][k*CB +: CB]);
    for (int k = 0; k < 3; k++) begin
      s0[k] = coord_t'(p0[k*CB +: CB]);
      s1[k] = coord_t'(p1[k*CB +: CB]);
      e1[k] = v[1][k] - v[0][k];
      e2[k] = v[2][k] - v[0][k];
    end
    nrm[0] = e1[1]*e2[2] - e1[2]*e2[1];
    nrm[1] = e1[2]*e2[0] - e1[0]*e2[2];
    nrm[2] = e1[0]*e2[1] - e1[1]*e2[0];
    da = 0; db = 0;
    for (int k = 0; k < 3; k++) begin
      da += (s0[k] - v[0][k]) * nrm[k];
      db += (s1[k] - v[0][k]) * nrm[k];
    end
    // drop: both endpoints strictly on one side
    if (da != 0 && db != 0 && ((da < 0) == (db < 0))) return r;
    ada = (da < 0) ? -da : da;
    sum = ada + ((db < 0) ? -db : db);
    if (sum == 0) return r;  // segment in plane or flat triangle
    for (int k = 0; k < 3; k++) begin
      dc = s1[k] - s0[k];
      num = ada * ((dc < 0) ? -dc : dc);
      q = num / sum;
      rem = num - q * sum;
      if (2 * rem >= sum) q += 1;
      xp[k] = (dc < 0) ? s0[k] - q : s0[k] + q;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      for (int k = 0; k < 3; k++) begin
        ed[k] = v[j][k] - v[i][k];
        rl[k] = xp[k] - v[j][k];
      end
      cr[0] = ed[1]*rl[2] - ed[2]*rl[1];
      cr[1] = ed[2]*rl[0] - ed[0]*rl[2];
      cr[2] = ed[0]*rl[1] - ed[1]*rl[0];
      dt = cr[0]*nrm[0] + cr[1]*nrm[1] + cr[2]*nrm[2];
      if (dt < 0) return r;  // outside this edge
    end
    r.hit = 1'b1;
    r.x = coord_t'(xp[0]);
    r.y = coord_t'(xp[1]);
    r.z = coord_t'(xp[2]);
    return r;
  endfunction

  // Offer one item, hold it until accepted, then queue its expectation.
  task automatic offer_item(logic [FIELD_W-1:0] a, b, c, p0, p1,
                            logic known, crossing_t want);
    crossing_t exp_hit;
    exp_hit = predict_crossing(a, b, c, p0, p1);
    if (known && exp_hit !== want) begin
      $error("table row disagrees with predictor: %h vs %h", want, exp_hit);
      errors++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tri_vertex_a_i <= a; tri_vertex_b_i <= b; tri_vertex_c_i <= c;
    seg_start_i <= p0; seg_end_i <= p1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_hits.push_back(exp_hit);
  endtask

  function automatic logic [FIELD_W-1:0] rand_word();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  function automatic int rc(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Well-formed case: segment straddling a random triangle, near its interior.
  task automatic offer_crossing();
    int sp, ax[3], ay[3], mx, my, z0, z1;
    sp = ($urandom_range(3) == 0) ? 16000 : 200;
    for (int i = 0; i < 3; i++) begin
      ax[i] = rc(sp); ay[i] = rc(sp);
    end
    mx = (ax[0] + ax[1] + ax[2]) / 3 + rc(sp / 4);
    my = (ay[0] + ay[1] + ay[2]) / 3 + rc(sp / 4);
    z0 = $urandom_range(16000); z1 = -int'($urandom_range(16000));
    offer_item(pt(ax[0], ay[0], rc(sp / 8)), pt(ax[1], ay[1], rc(sp / 8)),
               pt(ax[2], ay[2], rc(sp / 8)),
               pt(mx + rc(sp / 8), my + rc(sp / 8), z0),
               pt(mx + rc(sp / 8), my + rc(sp / 8), z1), 1'b0, '0);
  endtask

  stim_row_t directed[$];
  task automatic add_row(logic [FIELD_W-1:0] a, b, c, p0, p1,
                         logic known, crossing_t want);
    stim_row_t r;
    r.a = a; r.b = b; r.c = c; r.p0 = p0; r.p1 = p1; r.known = known; r.want = want;
    directed.push_back(r);
  endtask

  // Stimulus
  initial begin
    logic [FIELD_W-1:0] tA, tB, tC;
    tA = pt(0, 0, 0); tB = pt(1024, 0, 0); tC = pt(0, 1024, 0);
    add_row(tA, tB, tC, pt(256, 256, 512), pt(256, 256, -512), 1'b1,
            {1'b1, 16'sd256, 16'sd256, 16'sd0});
    add_row(tA, tB, tC, pt(256, 256, 512), pt(256, 256, 100), 1'b1, '0);   // same side
    add_row(tA, tB, tC, pt(10, 10, 0), pt(500, 20, 0), 1'b1, '0);          // in plane
    add_row(tA, tA, tC, pt(10, 10, 5), pt(10, 10, -5), 1'b1, '0);          // flat triangle
    add_row(tA, tB, tC, pt(100, 100, 0), pt(100, 100, 300), 1'b1,
            {1'b1, 16'sd100, 16'sd100, 16'sd0});
    add_row(tA, tB, tC, pt(5, 7, 40), pt(5, 7, 0), 1'b1, {1'b1, 16'sd5, 16'sd7, 16'sd0});
    add_row(tA, tB, tC, pt(512, 512, 9), pt(512, 512, -9), 1'b1,
            {1'b1, 16'sd512, 16'sd512, 16'sd0});
    add_row(tA, tB, tC, pt(0, 0, 9), pt(0, 0, -9), 1'b1, {1'b1, 16'sd0, 16'sd0, 16'sd0});
    add_row(tA, tB, tC, pt(900, 900, 9), pt(900, 900, -9), 1'b1, '0);      // outside edge
    add_row(tA, tB, tC, pt(0, 0, 1), pt(3, 5, -2), 1'b0, '0);              // rounding
    add_row(tA, tB, tC, pt(-1, 1, 1), pt(2, -2, -2), 1'b0, '0);
    add_row(pt(-32768, -32768, -32768), pt(32767, -32768, -32768), pt(-32768, 32767, 32767),
            pt(0, 0, -32768), pt(0, 0, 32767), 1'b0, '0);
    add_row(pt(32767, 32767, 32767), pt(-32768, 32767, -32768), pt(32767, -32768, -32768),
            pt(-32768, -32768, 32767), pt(32767, 32767, -32768), 1'b0, '0);
    add_row('1, '0, '1, '0, '1, 1'b0, '0);
    add_row({48{1'b1}}, {16'h8000, 16'h7fff, 16'h8000}, 48'h7fff_8000_7fff,
            48'h8000_8000_8000, 48'h7fff_7fff_7fff, 1'b0, '0);
    add_row(pt(-300, -300, 50), pt(300, -300, 50), pt(0, 300, 50),
            pt(-7, 3, 32767), pt(11, -5, -32768), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      offer_item(directed[i].a, directed[i].b, directed[i].c, directed[i].p0,
                 directed[i].p1, directed[i].known, directed[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 50; recv_idle_pct = 11;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (n == 100) hold_off = 1'b1;
      if ($urandom_range(9) < 7) offer_crossing();
      else offer_item(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      1'b0, '0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int held;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < 200; held++) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o); errors++;
        end
        if (hit_x_o !== want.x) begin
          $error("hit_x: expected %0d, got %0d", want.x, hit_x_o); errors++;
        end
        if (hit_y_o !== want.y) begin
          $error("hit_y: expected %0d, got %0d", want.y, hit_y_o); errors++;
        end
        if (hit_z_o !== want.z) begin
          $error("hit_z: expected %0d, got %0d", want.z, hit_z_o); errors++;
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (stim_done && pending_hits.size() == 0) break;
    end
    repeat (CB + 40) @(posedge clk_i);
    if (errors == 0 && pending_hits.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
